### rtl/core/htd_pkg.sv
// Shared types and constants for the table-driven Huffman decoder.
package htd_pkg;

  localparam int SymbolCountDef = 256;
  localparam int CodeBitsDef    = 31;
  localparam int GroupSize      = 16;
  localparam int PadLimit       = 7;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_DECODE = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_MAX_LEN = 2'd0,
    CFG_ROOM    = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_CMP,
    S_GRP,
    S_RES,
    S_END,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       done;
    logic       status;
    logic       sym_valid;
    logic [7:0] symbol;
    logic       last;
  } result_t;

endpackage

### rtl/core/huffman_table_decoder_unit.sv
// Top level of the table-driven bit-serial Huffman decoder.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+--------------------------------------
//  s_axis    | in  | s_axis_tvalid_i/tready_o   | tuser: req_type; tdata: entry fields, byte
//  m_axis    | out | m_axis_tvalid_o/tready_i   | tdata: symbol; tuser: flags; tlast: last
//  cfg       | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// Each decoded bit passes through four steps: shift, registered match in every table cell,
// registered lowest-match search per group of sixteen cells, then the final pick.
// Reset clears all entry lengths at once; no clearing pass is needed.
// A stalled output holds the engine where a result must be placed; input is taken
// only while the engine is idle.
module huffman_table_decoder_unit import htd_pkg::*; #(
  parameter int SYMBOL_COUNT = SymbolCountDef,
  parameter int CODE_BITS    = CodeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] entry_symbol, [38:8] entry_code, [43:39] entry_length, [51:44] data_byte
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] symbol
  output logic [7:0]  m_axis_tdata_o,
  // [0] symbol_valid, [1] status, [2] message_done
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int NGrp = (SYMBOL_COUNT + GroupSize - 1) / GroupSize;

  // Input fields
  logic [7:0]  in_sym;
  logic [30:0] in_code;
  logic [4:0]  in_len;
  logic [7:0]  in_byte;
  req_e        in_req;
  logic        in_xfer;

  assign in_sym  = s_axis_tdata_i[7:0];
  assign in_code = s_axis_tdata_i[38:8];
  assign in_len  = s_axis_tdata_i[43:39];
  assign in_byte = s_axis_tdata_i[51:44];
  assign in_req  = req_e'(s_axis_tuser_i);

  state_e               state_q, state_d;
  logic [4:0]           max_len_q;
  logic [15:0]          room_q;
  logic [CODE_BITS-1:0] acc_q, acc_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [15:0]          emit_q, emit_d;
  logic                 err_q, err_d;
  logic [7:0]           byte_q, byte_d;
  logic [2:0]           bidx_q, bidx_d;
  logic                 pend_v_q, pend_v_d;
  logic [7:0]           pend_sym_q, pend_sym_d;
  result_t              out_q, out_d;
  logic                 out_v_q, out_v_d;
  logic                 out_free;

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Table cells
  logic [NGrp*GroupSize-1:0] match;
  logic [4:0]                wr_len;

  assign wr_len = (in_len > 5'(CODE_BITS)) ? 5'd0 : in_len;

  for (genvar i = 0; i < NGrp * GroupSize; i++) begin : g_cell
    if (i < SYMBOL_COUNT) begin : g_real
      htd_cell #(.CODE_BITS(CODE_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .wr_en_i    (in_xfer && (in_req == REQ_LOAD) && (in_sym == 8'(i))),
        .wr_code_i  (in_code[CODE_BITS-1:0]),
        .wr_len_i   (wr_len),
        .cmp_code_i (acc_q),
        .cmp_len_i  (cnt_q),
        .match_o    (match[i])
      );
    end else begin : g_pad
      assign match[i] = 1'b0;
    end
  end

  // Lowest match per group, registered
  logic [NGrp-1:0] grp_hit_q;
  logic [3:0]      grp_idx_d [NGrp];
  logic [3:0]      grp_idx_q [NGrp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_hit_q <= '0;
    end else begin
      for (int g = 0; g < NGrp; g++) begin
        grp_hit_q[g] <= |match[g*GroupSize +: GroupSize];
      end
    end
  end

  // Scan from the top so the lowest matching cell of each group wins
  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_idx_d[g] = '0;
      for (int k = GroupSize - 1; k >= 0; k--) begin
        if (match[g*GroupSize + k]) grp_idx_d[g] = 4'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGrp; g++) begin
      grp_idx_q[g] <= grp_idx_d[g];
    end
  end

  // Final pick over the groups
  logic       hit;
  logic [7:0] hit_sym;

  always_comb begin
    hit     = 1'b0;
    hit_sym = '0;
    for (int g = NGrp - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit     = 1'b1;
        hit_sym = 8'(g * GroupSize) | {4'd0, grp_idx_q[g]};
      end
    end
  end

  // Bit step helpers
  logic                 cur_bit;
  logic                 too_long;
  logic                 pad_bad;
  assign cur_bit  = byte_q[bidx_q];
  assign too_long = ({1'b0, cnt_q} + 6'd1 > {1'b0, max_len_q}) ||
                    ({1'b0, cnt_q} + 6'd1 > 6'(CODE_BITS));

  always_comb begin
    pad_bad = (cnt_q > 5'(PadLimit));
    for (int i = 0; i < 8; i++) begin
      if ((5'(i) < cnt_q) && !acc_q[i]) pad_bad = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_req == REQ_DECODE) begin
            state_d = (err_q || room_q == 16'd0) ? S_END : S_BIT;
          end else if (in_req == REQ_FINISH) begin
            state_d = S_FIN;
          end
        end
      end
      S_BIT:   state_d = too_long ? S_END : S_CMP;
      S_CMP:   state_d = S_GRP;
      S_GRP:   state_d = S_RES;
      S_RES: begin
        if (hit && emit_q >= room_q) begin
          state_d = S_END;
        end else if (!(hit && pend_v_q && !out_free)) begin
          state_d = (bidx_q == 3'd0) ? S_END : S_BIT;
        end
      end
      S_END:   if (out_free) state_d = S_IDLE;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    emit_d     = emit_q;
    err_d      = err_q;
    byte_d     = byte_q;
    bidx_d     = bidx_q;
    pend_v_d   = pend_v_q;
    pend_sym_d = pend_sym_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_axis_tready_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && in_req == REQ_DECODE) begin
          byte_d = in_byte;
          bidx_d = 3'd7;
          if (room_q == 16'd0) err_d = 1'b1;
        end
      end
      S_BIT: begin
        if (too_long) begin
          err_d = 1'b1;
        end else begin
          acc_d = {acc_q[CODE_BITS-2:0], cur_bit};
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_RES: begin
        if (hit && emit_q >= room_q) begin
          err_d = 1'b1;
        end else if (!(hit && pend_v_q && !out_free)) begin
          bidx_d = bidx_q - 3'd1;
          if (hit) begin
            if (pend_v_q) begin
              out_d   = '{done: 1'b0, status: 1'b0, sym_valid: 1'b1,
                          symbol: pend_sym_q, last: 1'b0};
              out_v_d = 1'b1;
            end
            pend_v_d   = 1'b1;
            pend_sym_d = hit_sym;
            emit_d     = emit_q + 16'd1;
            acc_d      = '0;
            cnt_d      = '0;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_d    = '{done: 1'b0, status: err_q, sym_valid: pend_v_q,
                       symbol: pend_v_q ? pend_sym_q : 8'd0, last: 1'b1};
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d   = '{done: 1'b1, status: err_q || room_q == 16'd0 || pad_bad,
                      sym_valid: 1'b0, symbol: 8'd0, last: 1'b1};
          out_v_d = 1'b1;
          acc_d   = '0;
          cnt_d   = '0;
          emit_d  = '0;
          err_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      max_len_q <= '0;
      room_q    <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      emit_q    <= '0;
      err_q     <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      emit_q   <= emit_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i && cfg_index_i == CFG_MAX_LEN) max_len_q <= cfg_data_i[4:0];
      if (cfg_valid_i && cfg_index_i == CFG_ROOM)    room_q    <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bidx_q     <= bidx_d;
    pend_sym_q <= pend_sym_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.symbol;
  assign m_axis_tuser_o  = {out_q.done, out_q.status, out_q.sym_valid};
  assign m_axis_tlast_o  = out_q.last;

  // Accumulated length never runs past the code width
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(CODE_BITS)) else $error("bit count beyond code width");

  // A held symbol never survives into idle
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q) else $error("pending symbol left in idle");

  // A finish result is always the last one of its item
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.done) |-> out_q.last) else $error("finish result without last");

  // Message state is cleared the cycle after a finish result is placed
  a_fin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (cnt_q == 5'd0 && !err_q && emit_q == 16'd0))
    else $error("message state not cleared by finish");

endmodule

### rtl/core/htd_cell.sv
// One table entry: stored code and length, compared against the shared accumulator.
module htd_cell import htd_pkg::*; #(
  parameter int CODE_BITS = CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CODE_BITS-1:0] wr_code_i,
  input  logic [4:0]           wr_len_i,
  input  logic [CODE_BITS-1:0] cmp_code_i,
  input  logic [4:0]           cmp_len_i,
  output logic                 match_o
);

  logic [CODE_BITS-1:0] code_q;
  logic [4:0]           len_q;
  logic                 match_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      code_q <= wr_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      match_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        len_q <= wr_len_i;
      end
      match_q <= (len_q != 5'd0) && (len_q == cmp_len_i) && (code_q == cmp_code_i);
    end
  end

  assign match_o = match_q;

endmodule
